[rtl/core/fol_pkg.sv]
// fol_pkg: shared types and constants for the frequency-ordered list
// payload structs, command codes, controller states, datapath command/status
// no dependencies
package fol_pkg;

  localparam int ENTRIES    = 64;
  localparam int COUNT_BITS = 32;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int ACT_W      = 7;
  localparam int ACT_RESET  = 64;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] CMD_INC   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] item_id;
    logic [5:0] query_rank;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  item_rank;
    logic [5:0]  item_at_rank;
    logic [31:0] item_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_ENT,
    S_RD_CNT,
    S_INC,
    S_WALK_RD,
    S_WALK_FETCH,
    S_WALK_CMP,
    S_PLACE,
    S_FIN
  } fol_state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic fetch;
    logic load_read;
    logic inc;
    logic shift;
    logic place;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic inc_ok;
    logic rd_ok;
    logic is_clear;
    logic r_zero;
    logic prev_ge;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/core/fol_dpath.sv]
// fol_dpath: count, rank and entry tables with validity flags, walk registers
// and the result register; driven by fol_ctrl commands
// depends on fol_pkg
module fol_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  fol_pkg::req_t                 req,
  input  logic                          cfg_we,
  input  logic [fol_pkg::ACT_W-1:0]     cfg_wdata,
  input  fol_pkg::dp_cmd_t              cmd,
  output fol_pkg::dp_stat_t             stat,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output fol_pkg::rsp_t                 rsp
);
  import fol_pkg::*;

  logic [ACT_W-1:0]      active_entries;
  logic [IDX_W-1:0]      id;
  logic [IDX_W-1:0]      r;
  logic [IDX_W-1:0]      prev;
  logic [COUNT_BITS-1:0] c;
  rsp_t                  res;

  logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
  logic [IDX_W-1:0]      r2e_mem [ENTRIES];
  logic [IDX_W-1:0]      e2r_mem [ENTRIES];
  logic [ENTRIES-1:0]    cnt_vld, r2e_vld, e2r_vld;

  logic [COUNT_BITS-1:0] cnt_q;
  logic [IDX_W-1:0]      r2e_q, e2r_q, r2e_ra_q, e2r_ra_q;
  logic                  cnt_rv, r2e_rv, e2r_rv;

  logic [IDX_W-1:0]      id_in, q_in;
  logic [IDX_W-1:0]      cnt_raddr, r2e_raddr;
  logic [COUNT_BITS-1:0] cnt_rd, c_next;
  logic [IDX_W-1:0]      r2e_rd, e2r_rd;
  logic                  id_ok, q_ok, reject;
  logic                  r2e_we, e2r_we;
  logic [IDX_W-1:0]      r2e_wdata, e2r_waddr;

  assign id_in = IDX_W'(req.item_id);
  assign q_in  = IDX_W'(req.query_rank);

  assign id_ok = (32'(req.item_id) < 32'(active_entries)) &&
                 (32'(req.item_id) < 32'(ENTRIES));
  assign q_ok  = (32'(req.query_rank) < 32'(active_entries)) &&
                 (32'(req.query_rank) < 32'(ENTRIES));
  assign reject = ((req.cmd == CMD_INC) && !id_ok) || ((req.cmd == CMD_READ) && !q_ok);

  // entries never written read as their reset values
  assign cnt_rd = cnt_rv ? cnt_q : '0;
  assign r2e_rd = r2e_rv ? r2e_q : r2e_ra_q;
  assign e2r_rd = e2r_rv ? e2r_q : e2r_ra_q;

  assign c_next = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;

  assign cnt_raddr = cmd.accept ? id_in : r2e_rd;
  assign r2e_raddr = cmd.accept ? q_in : r - 1'b1;

  assign r2e_we    = cmd.shift || cmd.place;
  assign r2e_wdata = cmd.place ? id : prev;
  assign e2r_we    = cmd.shift || cmd.place;
  assign e2r_waddr = cmd.place ? id : prev;

  always_comb begin
    stat.inc_ok   = (req.cmd == CMD_INC) && id_ok;
    stat.rd_ok    = (req.cmd == CMD_READ) && q_ok;
    stat.is_clear = (req.cmd == CMD_CLEAR);
    stat.r_zero   = (r == '0);
    stat.prev_ge  = (cnt_rd >= c);
    stat.out_free = !rsp_valid || rsp_ready;
  end

  // table storage
  always_ff @(posedge clk) begin
    if (cmd.inc) begin
      cnt_mem[id] <= c_next;
    end
    cnt_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (r2e_we) begin
      r2e_mem[r] <= r2e_wdata;
    end
    r2e_q    <= r2e_mem[r2e_raddr];
    r2e_ra_q <= r2e_raddr;
  end

  always_ff @(posedge clk) begin
    if (e2r_we) begin
      e2r_mem[e2r_waddr] <= r;
    end
    e2r_q    <= e2r_mem[id_in];
    e2r_ra_q <= id_in;
  end

  always_ff @(posedge clk) begin
    cnt_rv <= cnt_vld[cnt_raddr];
    r2e_rv <= r2e_vld[r2e_raddr];
    e2r_rv <= e2r_vld[id_in];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cnt_vld <= '0;
      r2e_vld <= '0;
      e2r_vld <= '0;
    end else begin
      if (cmd.inc) begin
        cnt_vld[id] <= 1'b1;
      end
      if (r2e_we) begin
        r2e_vld[r] <= 1'b1;
      end
      if (e2r_we) begin
        e2r_vld[e2r_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACT_W'(ACT_RESET);
    end else if (cfg_we) begin
      active_entries <= cfg_wdata;
    end
  end

  // walk and result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      id  <= id_in;
      res <= '{status: reject, item_rank: '0, item_at_rank: '0, item_count: '0};
    end
    if (cmd.fetch) begin
      prev <= r2e_rd;
    end
    if (cmd.load_read) begin
      res.item_at_rank <= 6'(prev);
      res.item_count   <= 32'(cnt_rd);
    end
    if (cmd.inc) begin
      c <= c_next;
      r <= e2r_rd;
    end
    if (cmd.shift) begin
      r <= r - 1'b1;
    end
    if (cmd.place) begin
      res.item_rank    <= 6'(r);
      res.item_at_rank <= 6'(id);
      res.item_count   <= 32'(c);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

[rtl/core/fol_ctrl.sv]
// fol_ctrl: sequencer for accept, rank read, increment and rank walk
// issues datapath commands from datapath status
// depends on fol_pkg
module fol_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  fol_pkg::dp_stat_t    stat,
  output fol_pkg::dp_cmd_t     cmd
);
  import fol_pkg::*;

  fol_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (stat.inc_ok) begin
            state_next = S_INC;
          end else if (stat.rd_ok) begin
            state_next = S_RD_ENT;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_RD_ENT:     state_next = S_RD_CNT;
      S_RD_CNT:     state_next = S_FIN;
      S_INC:        state_next = S_WALK_RD;
      S_WALK_RD:    state_next = stat.r_zero ? S_PLACE : S_WALK_FETCH;
      S_WALK_FETCH: state_next = S_WALK_CMP;
      S_WALK_CMP:   state_next = stat.prev_ge ? S_PLACE : S_WALK_RD;
      S_PLACE:      state_next = S_FIN;
      S_FIN: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready  = !rst;
        cmd.accept = req_valid && !rst;
        cmd.clear  = req_valid && !rst && stat.is_clear;
      end
      S_RD_ENT:     cmd.fetch = 1'b1;
      S_RD_CNT:     cmd.load_read = 1'b1;
      S_INC:        cmd.inc = 1'b1;
      S_WALK_RD:    cmd = '0;
      S_WALK_FETCH: cmd.fetch = 1'b1;
      S_WALK_CMP:   cmd.shift = !stat.prev_ge;
      S_PLACE:      cmd.place = 1'b1;
      S_FIN:        cmd.push = stat.out_free;
      default:      cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.fetch, cmd.load_read, cmd.inc, cmd.shift, cmd.place, cmd.push}))
    else $error("more than one datapath operation at once");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> stat.out_free)
    else $error("result pushed over a pending beat");
  a_inc_walk: assert property (@(posedge clk) disable iff (rst)
    cmd.inc |=> (state == S_WALK_RD))
    else $error("increment not followed by rank walk");
  a_shift_loop: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |=> (state == S_WALK_RD) && !cmd.accept)
    else $error("shift did not return to walk read");
  a_clear_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> cmd.accept)
    else $error("clear without accepted beat");
`endif

endmodule

[rtl/core/frequency_ordered_list.sv]
// frequency_ordered_list: lfu-style ranked list, one request beat at a time
// a read fetches the entry at the rank and its count; an increment walks its entry
// up the ranks until rank 0 or an equal or higher count stops the walk
// a new beat can be accepted while a result is still valid; a later result is held
// until the pending one is taken
// reset: counts zero, rank i holds entry i, active_entries 64, ready on release
module frequency_ordered_list (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  fol_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output fol_pkg::rsp_t             rsp,
  input  logic                      cfg_we,
  input  logic [fol_pkg::ACT_W-1:0] cfg_wdata
);
  import fol_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fol_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
